FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define LMFS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define LMFS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/lmfs_pkg.sv
package lmfs_pkg;

    // panel geometry
    localparam int PANEL_WIDTH = 24;
    localparam int SCAN_ROWS   = 8;
    localparam int BANDS       = 3;
    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int PANEL_ROWS  = SCAN_ROWS * BANDS;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_ROWS;
    localparam int LANES       = BANDS * ROW_BYTES;
    localparam int ROW_W       = $clog2(SCAN_ROWS);
    localparam int LANE_W      = $clog2(LANES);

    // field widths
    localparam int FUNC_W   = 2;
    localparam int COORD_W  = 5;
    localparam int INDEX_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int BAND_W   = 24;
    localparam int DRIVE_W  = 8;
    localparam int SROW_W   = 3;

    // slave tdata layout
    localparam int S_TDATA_W   = 32;
    localparam int S_X_LO      = 0;
    localparam int S_Y_LO      = S_X_LO + COORD_W;
    localparam int S_ON_BIT    = S_Y_LO + COORD_W;
    localparam int S_IDX_LO    = S_ON_BIT + 1;
    localparam int S_VAL_LO    = S_IDX_LO + INDEX_W;
    localparam int S_INV_BIT   = S_VAL_LO + BYTE_W;

    // master tdata layout
    localparam int M_TDATA_W   = 88;
    localparam int M_LOWER_LO  = 0;
    localparam int M_MIDDLE_LO = M_LOWER_LO + BAND_W;
    localparam int M_UPPER_LO  = M_MIDDLE_LO + BAND_W;
    localparam int M_DRIVE_LO  = M_UPPER_LO + BAND_W;
    localparam int M_SROW_LO   = M_DRIVE_LO + DRIVE_W;
    localparam int M_USED_W    = M_SROW_LO + SROW_W;

    localparam logic [BYTE_W-1:0] PIXEL_MSB = 8'h80;

    typedef enum logic [FUNC_W-1:0] {
        OP_TICK  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_LOAD  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_TICK  = 3'b010,
        ST_PIXEL = 3'b100
    } state_t;

    // store row of a byte index, index / 3 by reciprocal, exact below 128
    function automatic logic [5:0] load_row(input logic [INDEX_W-1:0] idx);
        logic [15:0] prod;
        prod = 16'(idx) * 16'd171;
        return prod[14:9];
    endfunction

endpackage

FILE: rtl/led_matrix_framebuffer_scanner_core.sv
// channel   dir  tdata                                         tuser
// s_        in   x, y, on, byte_index, byte_value, invert      func
// m_        out  lower, middle, upper band bits, drive, row    -
//
// byte load and clear finish as the item is taken, a pixel write reads, then writes back
// a scan tick goes through the lane memory read, then the output register
// the frame store sits in nine byte lanes of eight rows, all read together
// reset clears the per-byte valid flags at once, so no clearing pass is needed
// a tick waits in the tick state while the output register is still held

module led_matrix_framebuffer_scanner_core
    import lmfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pixel_x, pixel_y, pixel_on, byte_index, byte_value, invert, zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [FUNC_W-1:0]     s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lower_band_bits, middle_band_bits, upper_band_bits, row_drive, scan_row,
    // zero fill
    output logic [M_TDATA_W-1:0]  m_tdata
);

    op_t                in_func;
    logic [COORD_W-1:0] pix_x;
    logic [COORD_W-1:0] pix_y;
    logic               pix_on;
    logic [INDEX_W-1:0] byte_index;
    logic [BYTE_W-1:0]  byte_value;
    logic               invert;

    assign in_func    = op_t'(s_tuser);
    assign pix_x      = s_tdata[S_X_LO +: COORD_W];
    assign pix_y      = s_tdata[S_Y_LO +: COORD_W];
    assign pix_on     = s_tdata[S_ON_BIT];
    assign byte_index = s_tdata[S_IDX_LO +: INDEX_W];
    assign byte_value = s_tdata[S_VAL_LO +: BYTE_W];
    assign invert     = s_tdata[S_INV_BIT];

    // pixel write placement
    logic              pix_ok;
    logic [ROW_W-1:0]  pix_row;
    logic [LANE_W-1:0] pix_lane;
    logic [BYTE_W-1:0] pix_mask;

    assign pix_ok   = (pix_x < COORD_W'(PANEL_WIDTH)) && (pix_y < COORD_W'(PANEL_ROWS));
    assign pix_row  = pix_y[ROW_W-1:0];
    assign pix_lane = LANE_W'(pix_y >> ROW_W) * LANE_W'(ROW_BYTES) + LANE_W'(pix_x >> 3);
    assign pix_mask = PIXEL_MSB >> pix_x[2:0];

    // byte load placement
    logic              ld_ok;
    logic [5:0]        ld_grow;
    logic [INDEX_W-1:0] ld_three;
    logic [1:0]        ld_col;
    logic [ROW_W-1:0]  ld_row;
    logic [LANE_W-1:0] ld_lane;
    logic [BYTE_W-1:0] ld_data;

    assign ld_ok    = byte_index < INDEX_W'(STORE_BYTES);
    assign ld_grow  = load_row(byte_index);
    assign ld_three = {ld_grow, 1'b0} + {1'b0, ld_grow};
    assign ld_col   = 2'(byte_index - ld_three);
    assign ld_row   = ld_grow[ROW_W-1:0];
    assign ld_lane  = LANE_W'(ld_grow >> ROW_W) * LANE_W'(ROW_BYTES) + LANE_W'(ld_col);
    assign ld_data  = invert ? ~byte_value : byte_value;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [LANES-1:0]   valid_reg [SCAN_ROWS];
    logic [LANES-1:0]   valid_next [SCAN_ROWS];
    logic [ROW_W-1:0]   hold_row_reg, hold_row_next;
    logic [LANE_W-1:0]  hold_lane_reg, hold_lane_next;
    logic [BYTE_W-1:0]  hold_mask_reg, hold_mask_next;
    logic               hold_on_reg, hold_on_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // lane memories
    logic [BYTE_W-1:0]  lane_mem [LANES][SCAN_ROWS];
    logic [BYTE_W-1:0]  rd_data_reg [LANES];
    logic [ROW_W-1:0]   rd_row;
    logic               mem_we;
    logic [LANE_W-1:0]  mem_wr_lane;
    logic [ROW_W-1:0]   mem_wr_row;
    logic [BYTE_W-1:0]  mem_wr_data;

    assign rd_row = (state_reg != ST_IDLE) ? hold_row_reg :
                    (in_func == OP_TICK)   ? row_cnt_reg  : pix_row;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        always_ff @(posedge aclk) begin
            if (mem_we && mem_wr_lane == LANE_W'(l)) begin
                lane_mem[l][mem_wr_row] <= mem_wr_data;
            end
            rd_data_reg[l] <= lane_mem[l][rd_row];
        end
    end

    // bytes not written since reset or the last clear read as zero
    logic [BYTE_W-1:0]  lane_byte [LANES];
    logic [BAND_W-1:0]  band_line [BANDS];
    logic [BYTE_W-1:0]  pix_old;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_byte[l] = valid_reg[hold_row_reg][l] ? rd_data_reg[l] : '0;
        end
        for (int b = 0; b < BANDS; b++) begin
            band_line[b] = '0;
            for (int i = 0; i < ROW_BYTES; i++) begin
                band_line[b][(ROW_BYTES-1-i)*BYTE_W +: BYTE_W] = ~lane_byte[b*ROW_BYTES+i];
            end
        end
    end

    assign pix_old = lane_byte[hold_lane_reg];

    always_comb begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        valid_next     = valid_reg;
        hold_row_next  = hold_row_reg;
        hold_lane_next = hold_lane_reg;
        hold_mask_next = hold_mask_reg;
        hold_on_next   = hold_on_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        mem_we         = 1'b0;
        mem_wr_lane    = ld_lane;
        mem_wr_row     = ld_row;
        mem_wr_data    = ld_data;
        s_tready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_func)
                        OP_TICK: begin
                            hold_row_next = row_cnt_reg;
                            state_next    = ST_TICK;
                        end
                        OP_PIXEL: begin
                            if (pix_ok) begin
                                hold_row_next  = pix_row;
                                hold_lane_next = pix_lane;
                                hold_mask_next = pix_mask;
                                hold_on_next   = pix_on;
                                state_next     = ST_PIXEL;
                            end
                        end
                        OP_LOAD: begin
                            if (ld_ok) begin
                                mem_we                      = 1'b1;
                                valid_next[ld_row][ld_lane] = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            for (int r = 0; r < SCAN_ROWS; r++) begin
                                valid_next[r] = '0;
                            end
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[M_LOWER_LO +: BAND_W]  = band_line[2];
                    m_tdata_next[M_MIDDLE_LO +: BAND_W] = band_line[1];
                    m_tdata_next[M_UPPER_LO +: BAND_W]  = band_line[0];
                    m_tdata_next[M_DRIVE_LO +: DRIVE_W] =
                        ~(DRIVE_W'(1) << hold_row_reg);
                    m_tdata_next[M_SROW_LO +: SROW_W]   = SROW_W'(hold_row_reg);
                    row_cnt_next = (hold_row_reg == ROW_W'(SCAN_ROWS - 1)) ?
                                   '0 : hold_row_reg + 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_PIXEL: begin
                mem_we      = 1'b1;
                mem_wr_lane = hold_lane_reg;
                mem_wr_row  = hold_row_reg;
                mem_wr_data = hold_on_reg ? (pix_old | hold_mask_reg)
                                          : (pix_old & ~hold_mask_reg);
                valid_next[hold_row_reg][hold_lane_reg] = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            for (int r = 0; r < SCAN_ROWS; r++) begin
                valid_reg[r] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            row_cnt_reg  <= row_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_row_reg  <= hold_row_next;
        hold_lane_reg <= hold_lane_next;
        hold_mask_reg <= hold_mask_next;
        hold_on_reg   <= hold_on_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/lmfs_checker.sv
`include "assert_macros.svh"

module lmfs_checker
    import lmfs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [FUNC_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic s_xfer;
    logic tick_xfer;

    assign s_xfer    = s_tvalid && s_tready;
    assign tick_xfer = s_xfer && (s_tuser == OP_TICK);

    // nothing left on the result side after reset
    `LMFS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // store operations never produce a scan line
    `LMFS_ASSERT(a_no_spurious, aclk, aresetn, (s_xfer && s_tuser != OP_TICK && !m_tvalid) |=> !m_tvalid, "result without a tick")

    // a tick holds off the next transfer while its line is built
    `LMFS_ASSERT(a_tick_busy, aclk, aresetn, tick_xfer |=> !s_tready, "input taken during tick")

    // with the output side free, the line follows the tick via the tick state and the output register
    `LMFS_ASSERT(a_tick_line, aclk, aresetn, (tick_xfer && (!m_tvalid || m_tready)) |=> ##1 m_tvalid, "scan line missing")

    // padding above the scan row stays zero
    `LMFS_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> (m_tdata[M_TDATA_W-1:M_USED_W] == '0), "tdata padding set")

endmodule

bind led_matrix_framebuffer_scanner_core lmfs_checker u_lmfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lmfs_pkg::*;

    localparam int RX_HOLD_CYCLES = 150;
    localparam int QUIET_LIMIT    = 4000;
    localparam int PHASE_ITEMS    = 300;

    class scan_line_scoreboard;
        typedef struct {
            logic [BAND_W-1:0]  lower;
            logic [BAND_W-1:0]  middle;
            logic [BAND_W-1:0]  upper;
            logic [DRIVE_W-1:0] drive;
            logic [SROW_W-1:0]  row;
        } scan_line_t;

        logic [BYTE_W-1:0] frame [STORE_BYTES];
        logic [ROW_W-1:0]  row_ctr;
        scan_line_t        pending_lines [$];
        int                errors;

        function new();
            foreach (frame[i]) frame[i] = '0;
            row_ctr = '0;
            errors  = 0;
        endfunction

        // inverted row bytes, first byte ends up in the top bits
        function logic [BAND_W-1:0] band_bits(int band, logic [ROW_W-1:0] h);
            logic [BAND_W-1:0] v;
            int                row;
            v   = '0;
            row = band * SCAN_ROWS + int'(h);
            for (int i = 0; i < ROW_BYTES; i++)
                v = {v[BAND_W-BYTE_W-1:0], ~frame[row * ROW_BYTES + i]};
            return v;
        endfunction

        function void apply_item(op_t op, logic [S_TDATA_W-1:0] data);
            scan_line_t        line;
            int                px;
            int                py;
            int                idx;
            logic [BYTE_W-1:0] val;
            logic [BYTE_W-1:0] mask;
            px  = int'(data[S_X_LO +: COORD_W]);
            py  = int'(data[S_Y_LO +: COORD_W]);
            idx = int'(data[S_IDX_LO +: INDEX_W]);
            val = data[S_VAL_LO +: BYTE_W];
            case (op)
                OP_TICK: begin
                    line.lower  = band_bits(2, row_ctr);
                    line.middle = band_bits(1, row_ctr);
                    line.upper  = band_bits(0, row_ctr);
                    line.drive  = ~(DRIVE_W'(1) << row_ctr);
                    line.row    = SROW_W'(row_ctr);
                    pending_lines.push_back(line);
                    row_ctr = (int'(row_ctr) == SCAN_ROWS - 1) ? '0 : row_ctr + 1'b1;
                end
                OP_PIXEL: begin
                    // coordinates off the panel leave the store alone
                    if (px < PANEL_WIDTH && py < PANEL_ROWS) begin
                        mask = PIXEL_MSB >> (px % 8);
                        if (data[S_ON_BIT])
                            frame[py * ROW_BYTES + px / 8] |= mask;
                        else
                            frame[py * ROW_BYTES + px / 8] &= ~mask;
                    end
                end
                OP_LOAD: begin
                    if (idx < STORE_BYTES)
                        frame[idx] = data[S_INV_BIT] ? ~val : val;
                end
                OP_CLEAR: begin
                    foreach (frame[i]) frame[i] = '0;
                end
            endcase
        endfunction

        function void check_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %h, actual %h", field, want, got);
                errors++;
            end
        endfunction

        function void check_scan_line(logic [M_TDATA_W-1:0] data);
            scan_line_t line;
            if (pending_lines.size() == 0) begin
                $error("scan line transfer with none expected: %h", data);
                errors++;
                return;
            end
            line = pending_lines.pop_front();
            check_field("lower_band_bits", 32'(line.lower), 32'(data[M_LOWER_LO +: BAND_W]));
            check_field("middle_band_bits", 32'(line.middle),
                        32'(data[M_MIDDLE_LO +: BAND_W]));
            check_field("upper_band_bits", 32'(line.upper), 32'(data[M_UPPER_LO +: BAND_W]));
            check_field("row_drive", 32'(line.drive), 32'(data[M_DRIVE_LO +: DRIVE_W]));
            check_field("scan_row", 32'(line.row), 32'(data[M_SROW_LO +: SROW_W]));
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    scan_line_scoreboard sb;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req_cnt = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    led_matrix_framebuffer_scanner_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // result side: check each transfer, then pick next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_scan_line(m_tdata);
        if (hold_seen != hold_req_cnt) begin
            hold_seen <= hold_req_cnt;
            hold_left <= RX_HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_item(input op_t op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic on,
                             input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val,
                             input logic inv);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[S_X_LO +: COORD_W]   = x;
        data[S_Y_LO +: COORD_W]   = y;
        data[S_ON_BIT]            = on;
        data[S_IDX_LO +: INDEX_W] = idx;
        data[S_VAL_LO +: BYTE_W]  = val;
        data[S_INV_BIT]           = inv;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.apply_item(op, data);
    endtask

    task automatic send_random_item();
        int                   pick;
        op_t                  op;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [INDEX_W-1:0]   idx;
        pick = $urandom_range(99);
        if (pick < 40)
            op = OP_TICK;
        else if (pick < 70)
            op = OP_PIXEL;
        else if (pick < 97)
            op = OP_LOAD;
        else
            op = OP_CLEAR;
        // mostly on the panel, now and then off it
        x   = ($urandom_range(9) == 0) ? COORD_W'($urandom_range(31))
                                       : COORD_W'($urandom_range(PANEL_WIDTH - 1));
        y   = ($urandom_range(9) == 0) ? COORD_W'($urandom_range(31))
                                       : COORD_W'($urandom_range(PANEL_ROWS - 1));
        idx = ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(127))
                                       : INDEX_W'($urandom_range(STORE_BYTES - 1));
        send_item(op, x, y, 1'($urandom), idx, BYTE_W'($urandom), 1'($urandom));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_lines.size() != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        repeat (PHASE_ITEMS / 3) send_random_item();
        // long receiver hold-off while items keep coming
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (PHASE_ITEMS - PHASE_ITEMS / 3) send_random_item();
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store after reset
        send_item(OP_TICK, 0, 0, 0, 0, 8'h00, 0);
        send_item(OP_LOAD, 0, 0, 0, 0, 8'hA5, 0);
        send_item(OP_LOAD, 0, 0, 0, INDEX_W'(STORE_BYTES - 1), 8'h00, 1);
        // indexes past the store are dropped
        send_item(OP_LOAD, 0, 0, 0, INDEX_W'(STORE_BYTES), 8'hFF, 0);
        send_item(OP_LOAD, 0, 0, 0, 7'h7F, 8'h5A, 1);
        send_item(OP_PIXEL, 0, 0, 1, 0, 0, 0);
        send_item(OP_PIXEL, 23, 23, 1, 0, 0, 0);
        send_item(OP_PIXEL, 31, 31, 1, 0, 0, 0);
        send_item(OP_PIXEL, 24, 0, 1, 0, 0, 0);
        send_item(OP_PIXEL, 0, 24, 1, 0, 0, 0);
        send_item(OP_PIXEL, 0, 0, 0, 0, 0, 0);
        send_item(OP_PIXEL, 7, 8, 1, 0, 0, 0);
        send_item(OP_PIXEL, 8, 16, 1, 0, 0, 0);
        // full row sweep, wrapping back past the top
        repeat (SCAN_ROWS) send_item(OP_TICK, 0, 0, 0, 0, 8'h00, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 8'h00, 0);
        send_item(OP_TICK, 0, 0, 0, 0, 8'h00, 0);
        wait_drained();

        run_phase(25, 68);
        run_phase(68, 25);
        run_phase(0, 0);

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_lines.size() == 0) begin
            $display("status: pass");
        end else begin
            if (sb.pending_lines.size() != 0)
                $error("%0d scan lines never arrived", sb.pending_lines.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lmfs_pkg.sv
rtl/led_matrix_framebuffer_scanner_core.sv
rtl/lmfs_checker.sv
dv/testbench.sv
